[sv/dfe_pkg.sv]
`default_nettype none
// Shared types and constants for the delimited field extractor.
package dfe_pkg;

    localparam int CFG_DATA_W = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int FIELD_W = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FIELD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_A = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_B = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_C = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_D = 3'd5;

    localparam logic [FIELD_W-1:0] FIELD_INDEX_MAX = 10'd1023;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_CLOSE
    } dfe_state_t;

    typedef struct packed {
        logic accept_en;
        logic rd_issue;
        logic emit_byte;
        logic emit_close;
    } dfe_cmd_t;

    typedef struct packed {
        logic out_free;
        logic dump_req;
        logic rd_last;
    } dfe_status_t;

endpackage
`default_nettype wire

[sv/dfe_ctrl.sv]
`default_nettype none
// Controller state machine: accepts items and sequences the end-of-line buffer dump.
module dfe_ctrl
    import dfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire dfe_status_t status,
    output dfe_cmd_t         cmd
);

    dfe_state_t state_reg;
    dfe_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.out_free && status.dump_req)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.rd_last ? S_CLOSE : S_READ;
                end
            end
            S_CLOSE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept_en = status.out_free;
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit_byte = status.out_free;
            end
            S_CLOSE:
            begin
                cmd.emit_close = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/dfe_datapath.sv]
`default_nettype none
// Datapath: configuration registers, field tracking, field buffer and output register.
module dfe_datapath
    import dfe_pkg::*;
#(
    parameter int MAX_FIELD_LEN = 63,
    parameter int DELIM_SLOTS = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    input  wire logic [7:0]             char_byte,
    input  wire logic                   line_end,
    input  wire logic                   out_ready,
    input  wire dfe_cmd_t               cmd,
    output dfe_status_t                 status,
    output logic                        out_valid,
    output logic [7:0]                  out_byte,
    output logic                        is_closing,
    output logic                        found,
    output logic                        truncated,
    output logic                        last_of_run
);

    localparam int LEN_W = $clog2(MAX_FIELD_LEN + 1);
    localparam int ADDR_W = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1;

    logic [FIELD_W-1:0] target_reg;
    logic [2:0]         delim_count_reg;
    logic [7:0]         delim_reg [4];

    logic [FIELD_W-1:0] field_index_reg;
    logic [FIELD_W-1:0] field_index_next;
    logic               inside_reg;
    logic               inside_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [ADDR_W-1:0]  rd_idx_reg;
    logic [ADDR_W-1:0]  rd_idx_next;

    logic [7:0]         buf_mem [MAX_FIELD_LEN];
    logic [7:0]         rdata_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_byte_next;
    logic               closing_reg;
    logic               closing_next;
    logic               found_reg;
    logic               found_next;
    logic               trunc_reg;
    logic               trunc_next;
    logic               last_reg;
    logic               last_next;

    logic               fire;
    logic               target_zero;
    logic               is_delim;
    logic [2:0]         used;
    logic [FIELD_W-1:0] index_bumped;
    logic               buf_we;
    logic               clear_line;
    logic               direct_close;

    assign fire        = in_valid && cmd.accept_en;
    assign target_zero = (target_reg == '0);

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.dump_req = line_end && target_zero && (len_reg != '0);
    assign status.rd_last  = ((LEN_W'(rd_idx_reg) + LEN_W'(1)) == len_reg);

    always_comb
    begin
        used = (delim_count_reg > 3'(DELIM_SLOTS)) ? 3'(DELIM_SLOTS) : delim_count_reg;
        is_delim = 1'b0;
        for (int i = 0; i < DELIM_SLOTS; i++)
        begin
            if ((3'(i) < used) && (delim_reg[i] == char_byte))
            begin
                is_delim = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg      <= 10'd1;
            delim_count_reg <= 3'd2;
            delim_reg[0]    <= 8'd32;
            delim_reg[1]    <= 8'd9;
            delim_reg[2]    <= 8'd0;
            delim_reg[3]    <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_FIELD: target_reg      <= cfg_data;
                REG_DELIM_COUNT:  delim_count_reg <= cfg_data[2:0];
                REG_DELIM_A:      delim_reg[0]    <= cfg_data[7:0];
                REG_DELIM_B:      delim_reg[1]    <= cfg_data[7:0];
                REG_DELIM_C:      delim_reg[2]    <= cfg_data[7:0];
                REG_DELIM_D:      delim_reg[3]    <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // A line end either closes at once or, with a buffered field, hands over to the dump.
    assign direct_close = fire && line_end && !status.dump_req;
    assign clear_line   = direct_close || cmd.emit_close;

    always_comb
    begin
        field_index_next = field_index_reg;
        inside_next      = inside_reg;
        len_next         = len_reg;
        ovf_next         = ovf_reg;
        buf_we           = 1'b0;
        index_bumped     = field_index_reg;
        if (!inside_reg && (field_index_reg != FIELD_INDEX_MAX))
        begin
            index_bumped = field_index_reg + FIELD_W'(1);
        end
        if (clear_line)
        begin
            field_index_next = '0;
            inside_next      = 1'b0;
            len_next         = '0;
            ovf_next         = 1'b0;
        end
        else if (fire && !line_end)
        begin
            if (is_delim)
            begin
                inside_next = 1'b0;
            end
            else
            begin
                inside_next      = 1'b1;
                field_index_next = index_bumped;
                if (!inside_reg)
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                if (target_zero)
                begin
                    // A new field restarts the buffer, so the write lands at entry zero.
                    if (!inside_reg || (len_reg < LEN_W'(MAX_FIELD_LEN)))
                    begin
                        buf_we   = 1'b1;
                        len_next = inside_reg ? (len_reg + LEN_W'(1)) : LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (fire)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.emit_byte)
        begin
            rd_idx_next = rd_idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg <= '0;
            inside_reg      <= 1'b0;
            len_reg         <= '0;
            ovf_reg         <= 1'b0;
            rd_idx_reg      <= '0;
        end
        else
        begin
            field_index_reg <= field_index_next;
            inside_reg      <= inside_next;
            len_reg         <= len_next;
            ovf_reg         <= ovf_next;
            rd_idx_reg      <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[inside_reg ? len_reg[ADDR_W-1:0] : '0] <= char_byte;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= buf_mem[rd_idx_reg];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        closing_next   = closing_reg;
        found_next     = found_reg;
        trunc_next     = trunc_reg;
        last_next      = last_reg;
        if (direct_close)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'd0;
            closing_next   = 1'b1;
            found_next     = target_zero || (target_reg == FIELD_W'(1))
                             || (field_index_reg >= target_reg);
            trunc_next     = target_zero && ovf_reg;
            last_next      = 1'b1;
        end
        else if (fire && !line_end && !is_delim && !target_zero
                 && (index_bumped == target_reg))
        begin
            out_valid_next = 1'b1;
            out_byte_next  = char_byte;
            closing_next   = 1'b0;
            found_next     = 1'b0;
            trunc_next     = 1'b0;
            last_next      = 1'b1;
        end
        else if (cmd.emit_byte)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rdata_reg;
            closing_next   = 1'b0;
            found_next     = 1'b0;
            trunc_next     = 1'b0;
            last_next      = 1'b0;
        end
        else if (cmd.emit_close)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'd0;
            closing_next   = 1'b1;
            found_next     = 1'b1;
            trunc_next     = ovf_reg;
            last_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        closing_reg  <= closing_next;
        found_reg    <= found_next;
        trunc_reg    <= trunc_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign is_closing  = closing_reg;
    assign found       = found_reg;
    assign truncated   = trunc_reg;
    assign last_of_run = last_reg;

endmodule
`default_nettype wire

[sv/delimited_field_extractor_unit.sv]
`default_nettype none
// Top level of the delimited field extractor.
//
//  Channel  Signals                                           Handshake
//  -------  ------------------------------------------------  ---------------------
//  input    char_byte, line_end                               in_valid / in_ready
//  output   out_byte, is_closing, found, truncated, last_of_run  out_valid / out_ready
//  config   cfg_index, cfg_data                               cfg_we, no wait
//
// Bytes stream at one per cycle while the output register drains and no line-end dump is in progress.
// A line end in last-field mode with L buffered bytes is first accepted; then each byte of the
// dump passes through a buffer memory read and then the output register load, and last comes
// the closing item.
// Reset is asynchronous and active low; the field buffer itself is not cleared.
// A stalled output holds the item in the output register and stops input acceptance.
module delimited_field_extractor_unit
    import dfe_pkg::*;
#(
    parameter int MAX_FIELD_LEN = 63,
    parameter int DELIM_SLOTS = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             char_byte,
    input  wire logic                   line_end,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  out_byte,
    output logic                        is_closing,
    output logic                        found,
    output logic                        truncated,
    output logic                        last_of_run
);

    dfe_cmd_t    cmd;
    dfe_status_t status;

    dfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd)
    );

    dfe_datapath #(
        .MAX_FIELD_LEN (MAX_FIELD_LEN),
        .DELIM_SLOTS   (DELIM_SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .char_byte   (char_byte),
        .line_end    (line_end),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .is_closing  (is_closing),
        .found       (found),
        .truncated   (truncated),
        .last_of_run (last_of_run)
    );

    assign in_ready = cmd.accept_en;

endmodule
`default_nettype wire
